// File: hw/rtl/aes_cbc_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CBC package
// Beat types, status codes, register indexes and the AES round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_cbc_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int NUM_ROUNDS  = 10;

	typedef logic [127:0] state_t;
	typedef logic [NUM_ROUNDS:0][127:0] rkeys_t;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  byte_count;
		logic        first_block;
		logic        last_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic [4:0]  result_bytes;
		logic        result_last;
		logic [1:0]  status;
	} out_item_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_PAD = 2'd2;

	localparam logic [2:0] REG_KEY_HIGH = 3'd0;
	localparam logic [2:0] REG_KEY_LOW  = 3'd1;
	localparam logic [2:0] REG_IV_HIGH  = 3'd2;
	localparam logic [2:0] REG_IV_LOW   = 3'd3;
	localparam logic [2:0] REG_DIR      = 3'd4;
	localparam logic [2:0] REG_PAD      = 3'd5;

	localparam logic [0:255][7:0] SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [0:9][7:0] RCON = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

	// Inverse table, built at elaboration from the forward one.
	function automatic logic [0:255][7:0] build_inv_sbox();
		logic [0:255][7:0] t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			t[SBOX[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam logic [0:255][7:0] INV_SBOX = build_inv_sbox();

	function automatic logic [7:0] get_byte(input state_t s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic state_t sub_bytes(input state_t s);
		state_t r;
		for (int i = 0; i < 16; i++) begin
			r[127 - 8*i -: 8] = SBOX[get_byte(s, i)];
		end
		return r;
	endfunction

	function automatic state_t inv_sub_bytes(input state_t s);
		state_t r;
		for (int i = 0; i < 16; i++) begin
			r[127 - 8*i -: 8] = INV_SBOX[get_byte(s, i)];
		end
		return r;
	endfunction

	function automatic state_t shift_rows(input state_t s);
		state_t r;
		for (int c = 0; c < 4; c++) begin
			for (int w = 0; w < 4; w++) begin
				r[127 - 8*(w + 4*c) -: 8] = get_byte(s, w + 4*((c + w) % 4));
			end
		end
		return r;
	endfunction

	function automatic state_t inv_shift_rows(input state_t s);
		state_t r;
		for (int c = 0; c < 4; c++) begin
			for (int w = 0; w < 4; w++) begin
				r[127 - 8*(w + 4*((c + w) % 4)) -: 8] = get_byte(s, w + 4*c);
			end
		end
		return r;
	endfunction

	function automatic state_t mix_columns(input state_t s);
		state_t r;
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c + 1);
			a2 = get_byte(s, 4*c + 2);
			a3 = get_byte(s, 4*c + 3);
			r[127 - 8*(4*c)     -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			r[127 - 8*(4*c + 1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			r[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			r[127 - 8*(4*c + 3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return r;
	endfunction

	function automatic state_t inv_mix_columns(input state_t s);
		state_t r;
		logic [3:0][7:0] a, x2, x4, x8, m9, m11, m13, m14;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]   = get_byte(s, 4*c + k);
				x2[k]  = xt(a[k]);
				x4[k]  = xt(x2[k]);
				x8[k]  = xt(x4[k]);
				m9[k]  = x8[k] ^ a[k];
				m11[k] = x8[k] ^ x2[k] ^ a[k];
				m13[k] = x8[k] ^ x4[k] ^ a[k];
				m14[k] = x8[k] ^ x4[k] ^ x2[k];
			end
			r[127 - 8*(4*c)     -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
			r[127 - 8*(4*c + 1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
			r[127 - 8*(4*c + 2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
			r[127 - 8*(4*c + 3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
		end
		return r;
	endfunction

	function automatic rkeys_t expand_key(input state_t key);
		rkeys_t rk;
		logic [43:0][31:0] w;
		logic [31:0] t;
		for (int i = 0; i < 4; i++) begin
			w[i] = key[127 - 32*i -: 32];
		end
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if ((i % 4) == 0) begin
				t = {t[23:0], t[31:24]};
				t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
				t = t ^ {RCON[i/4 - 1], 24'h0};
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r <= NUM_ROUNDS; r++) begin
			rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		end
		return rk;
	endfunction

	function automatic state_t encrypt_block(input state_t pt, input rkeys_t rk);
		state_t s;
		s = pt ^ rk[0];
		for (int r = 1; r <= NUM_ROUNDS; r++) begin
			s = shift_rows(sub_bytes(s));
			if (r < NUM_ROUNDS) begin
				s = mix_columns(s);
			end
			s = s ^ rk[r];
		end
		return s;
	endfunction

	function automatic state_t decrypt_block(input state_t ct, input rkeys_t rk);
		state_t s;
		s = ct ^ rk[NUM_ROUNDS];
		for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
			s = inv_sub_bytes(inv_shift_rows(s)) ^ rk[r];
			if (r > 0) begin
				s = inv_mix_columns(s);
			end
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aes128_cbc_pkcs7_engine_core.sv
// ----------------------------------------------------------------------------
// AES-128 CBC engine with PKCS#7 padding
// Chains 16-byte blocks through a fully unrolled AES-128 cipher.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+---------------------------
//   in       | to core   | in_valid / in_stall  | in_data  (in_item_t)
//   out      | from core | out_valid / out_stall| out_data (out_item_t)
//   config   | to core   | write_en             | write_index / write_data
//
// One input beat can enter each cycle unless in_stall holds it; its result
// is registered into out_q from the staged beat s1_data. The cipher and the
// CBC chain update are both combinational, so the chain loop through the ten
// unrolled rounds sets the clock. An encrypted padded message that ends on a
// full block takes an extra pass for the pad block; in_stall is high in the
// cycle that issues the data block of that beat. Reset clears the key, IV,
// chain and all valid flags and sets encrypt and pad mode; round keys follow
// the key registers in the next cycle. out_stall holds the output register
// and backs up into in_stall only when the staged beat cannot move.
`default_nettype none

module aes128_cbc_pkcs7_engine_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire aes_cbc_pkg::in_item_t  in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output aes_cbc_pkg::out_item_t      out_data,
	input  wire logic                   write_en,
	input  wire logic [2:0]             write_index,
	input  wire logic [63:0]            write_data
);

	localparam logic PH_MAIN = 1'b0;
	localparam logic PH_PAD  = 1'b1;

	// Configuration registers
	logic [127:0] key_q;
	logic [127:0] iv_q;
	logic         dir_q;
	logic         pad_q;

	aes_cbc_pkg::rkeys_t rk_q;
	logic [127:0]        chain_q;

	// Staged input beat
	aes_cbc_pkg::in_item_t s1_data;
	logic                  s1_valid;
	logic                  phase_q;

	aes_cbc_pkg::out_item_t out_q;
	logic                   out_valid_q;

	logic         out_free;
	logic         advance;
	logic         s1_done;
	logic         in_accept;
	logic [127:0] blk;
	logic [127:0] ch_eff;
	logic [127:0] padded;
	logic [127:0] enc_in;
	logic [127:0] enc_out;
	logic [127:0] dec_out;
	logic [7:0]   pad_fill;
	logic [7:0]   pad_len;
	logic         empty_end;
	logic         bad_len;
	logic         extra;
	logic [127:0] chain_next;
	aes_cbc_pkg::out_item_t res;

	assign blk      = {s1_data.block_high, s1_data.block_low};
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = s1_valid && out_free;
	assign s1_done  = advance && !(phase_q == PH_MAIN && extra);
	assign in_stall = s1_valid && !s1_done;
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		// Reload the chain from the IV on the first block of a message.
		ch_eff = (phase_q == PH_MAIN && s1_data.first_block) ? iv_q : chain_q;
		empty_end = (s1_data.byte_count == 5'd0) && !pad_q && s1_data.last_block;
		bad_len = (s1_data.byte_count > 5'(aes_cbc_pkg::BLOCK_BYTES)) ||
			((s1_data.byte_count < 5'(aes_cbc_pkg::BLOCK_BYTES)) &&
			(!s1_data.last_block || !pad_q || !dir_q));
		extra = dir_q && pad_q && s1_data.last_block && !empty_end && !bad_len &&
			(s1_data.byte_count == 5'(aes_cbc_pkg::BLOCK_BYTES));

		// Fill bytes past the count with the pad length.
		pad_fill = {3'b000, 5'(aes_cbc_pkg::BLOCK_BYTES) - s1_data.byte_count};
		for (int i = 0; i < aes_cbc_pkg::BLOCK_BYTES; i++) begin
			padded[127 - 8*i -: 8] = (5'(i) < s1_data.byte_count) ?
				blk[127 - 8*i -: 8] : pad_fill;
		end

		enc_in  = (phase_q == PH_PAD) ? (chain_q ^ {16{8'h10}}) : (ch_eff ^ padded);
		enc_out = aes_cbc_pkg::encrypt_block(enc_in, rk_q);
		dec_out = aes_cbc_pkg::decrypt_block(blk, rk_q) ^ ch_eff;
		pad_len = dec_out[7:0];

		res = '0;
		chain_next = ch_eff;
		if (phase_q == PH_PAD) begin
			res.result_high  = enc_out[127:64];
			res.result_low   = enc_out[63:0];
			res.result_bytes = 5'(aes_cbc_pkg::BLOCK_BYTES);
			res.result_last  = 1'b1;
			res.status       = aes_cbc_pkg::ST_OK;
			chain_next       = enc_out;
		end else if (empty_end) begin
			res.result_last = 1'b1;
			res.status      = aes_cbc_pkg::ST_OK;
		end else if (bad_len) begin
			res.result_last = s1_data.last_block;
			res.status      = aes_cbc_pkg::ST_BAD_LEN;
		end else if (dir_q) begin
			res.result_high  = enc_out[127:64];
			res.result_low   = enc_out[63:0];
			res.result_bytes = 5'(aes_cbc_pkg::BLOCK_BYTES);
			res.result_last  = s1_data.last_block && !extra;
			res.status       = aes_cbc_pkg::ST_OK;
			chain_next       = enc_out;
		end else begin
			chain_next = blk;
			if (pad_q && s1_data.last_block) begin
				res.result_last = 1'b1;
				if (pad_len > 8'(aes_cbc_pkg::BLOCK_BYTES)) begin
					res.status = aes_cbc_pkg::ST_BAD_PAD;
				end else begin
					res.result_high  = dec_out[127:64];
					res.result_low   = dec_out[63:0];
					res.result_bytes = 5'(aes_cbc_pkg::BLOCK_BYTES) - pad_len[4:0];
					res.status       = aes_cbc_pkg::ST_OK;
				end
			end else begin
				res.result_high  = dec_out[127:64];
				res.result_low   = dec_out[63:0];
				res.result_bytes = 5'(aes_cbc_pkg::BLOCK_BYTES);
				res.result_last  = s1_data.last_block;
				res.status       = aes_cbc_pkg::ST_OK;
			end
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			iv_q  <= '0;
			dir_q <= 1'b1;
			pad_q <= 1'b1;
		end else if (write_en) begin
			unique case (write_index)
				aes_cbc_pkg::REG_KEY_HIGH: key_q[127:64] <= write_data;
				aes_cbc_pkg::REG_KEY_LOW:  key_q[63:0]   <= write_data;
				aes_cbc_pkg::REG_IV_HIGH:  iv_q[127:64]  <= write_data;
				aes_cbc_pkg::REG_IV_LOW:   iv_q[63:0]    <= write_data;
				aes_cbc_pkg::REG_DIR:      dir_q         <= write_data[0];
				aes_cbc_pkg::REG_PAD:      pad_q         <= write_data[0];
				default: ;
			endcase
		end
	end

	// Round keys track the key registers.
	always_ff @(posedge clk) begin
		rk_q <= aes_cbc_pkg::expand_key(key_q);
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_data <= in_data;
		end
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			phase_q     <= PH_MAIN;
			out_valid_q <= 1'b0;
			chain_q     <= '0;
		end else begin
			if (in_accept) begin
				s1_valid <= 1'b1;
			end else if (s1_done) begin
				s1_valid <= 1'b0;
			end
			if (advance) begin
				chain_q     <= chain_next;
				out_valid_q <= 1'b1;
				phase_q     <= (phase_q == PH_MAIN && extra) ? PH_PAD : PH_MAIN;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The pad phase always works on a staged beat.
	a_pad_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAD |-> s1_valid)
		else $error("pad phase without a staged beat");

	// No new beat enters while the data block of a padded full end is issued.
	a_pad_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MAIN && s1_valid && extra |-> in_stall)
		else $error("input taken before the pad block");

	// A bad pad always closes the message.
	a_bad_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == aes_cbc_pkg::ST_BAD_PAD |-> out_data.result_last)
		else $error("bad pad result not marked last");

	// The pad block follows a first result that is not last.
	a_pad_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q) |-> out_valid && !out_data.result_last)
		else $error("pad phase entered after a last result");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// AES-128 CBC engine testbench
// Sends directed and random messages through the engine in both directions,
// with and without padding. An internal cipher model predicts every result
// beat, and the results are checked in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	typedef logic [0:15][7:0] blk_t;

	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	aes_cbc_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	aes_cbc_pkg::out_item_t out_data;
	logic write_en;
	logic [2:0] write_index;
	logic [63:0] write_data;

	aes128_cbc_pkcs7_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.write_en(write_en),
		.write_index(write_index),
		.write_data(write_data)
	);

	// Shadow copy of the engine's configuration and chain.
	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic encrypt_q, padding_q;
	blk_t chain_q;
	logic [127:0] rkey [11];
	logic [7:0] inv_box [256];

	aes_cbc_pkg::out_item_t expected_beats [$];
	int errors;
	bit gaps_on;
	bit stalls_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0]) begin
				p = p ^ a;
			end
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic void build_round_keys();
		logic [31:0] w [44];
		logic [31:0] t;
		logic [127:0] k;
		k = {key_hi_q, key_lo_q};
		for (int i = 0; i < 4; i++) begin
			w[i] = k[127 - 32*i -: 32];
		end
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {aes_cbc_pkg::SBOX[t[31:24]], aes_cbc_pkg::SBOX[t[23:16]],
					aes_cbc_pkg::SBOX[t[15:8]], aes_cbc_pkg::SBOX[t[7:0]]};
				t = t ^ {aes_cbc_pkg::RCON[i/4 - 1], 24'h0};
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++) begin
			rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		end
	endfunction

	function automatic blk_t cipher_fwd(input blk_t v);
		blk_t s, t;
		s = v ^ rkey[0];
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++) begin
				s[i] = aes_cbc_pkg::SBOX[s[i]];
			end
			for (int c = 0; c < 4; c++) begin
				for (int w = 0; w < 4; w++) begin
					t[w + 4*c] = s[w + 4*((c + w) % 4)];
				end
			end
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					s[4*c]   = gf_mul(t[4*c], 8'd2) ^ gf_mul(t[4*c+1], 8'd3) ^
						t[4*c+2] ^ t[4*c+3];
					s[4*c+1] = t[4*c] ^ gf_mul(t[4*c+1], 8'd2) ^
						gf_mul(t[4*c+2], 8'd3) ^ t[4*c+3];
					s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_mul(t[4*c+2], 8'd2) ^
						gf_mul(t[4*c+3], 8'd3);
					s[4*c+3] = gf_mul(t[4*c], 8'd3) ^ t[4*c+1] ^ t[4*c+2] ^
						gf_mul(t[4*c+3], 8'd2);
				end
			end else begin
				s = t;
			end
			s = s ^ rkey[r];
		end
		return s;
	endfunction

	function automatic blk_t cipher_inv(input blk_t v);
		blk_t s, t;
		logic [7:0] a0, a1, a2, a3;
		s = v ^ rkey[10];
		for (int r = 9; r >= 0; r--) begin
			for (int c = 0; c < 4; c++) begin
				for (int w = 0; w < 4; w++) begin
					t[w + 4*((c + w) % 4)] = s[w + 4*c];
				end
			end
			for (int i = 0; i < 16; i++) begin
				s[i] = inv_box[t[i]];
			end
			s = s ^ rkey[r];
			if (r > 0) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c];
					a1 = s[4*c+1];
					a2 = s[4*c+2];
					a3 = s[4*c+3];
					s[4*c]   = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^
						gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
					s[4*c+1] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^
						gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
					s[4*c+2] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^
						gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
					s[4*c+3] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^
						gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
				end
			end
		end
		return s;
	endfunction

	function automatic void push_result(input blk_t d, input logic [4:0] nbytes,
		input logic last, input logic [1:0] st);
		aes_cbc_pkg::out_item_t e;
		e.result_high = d[0:7];
		e.result_low = d[8:15];
		e.result_bytes = nbytes;
		e.result_last = last;
		e.status = st;
		expected_beats.push_back(e);
	endfunction

	// Work out the result beats of one accepted input beat and advance the chain.
	function automatic void predict_block(input aes_cbc_pkg::in_item_t b);
		blk_t x, c, o;
		logic [4:0] cnt;
		logic [7:0] p;
		logic extra;
		cnt = b.byte_count;
		if (b.first_block) begin
			chain_q = {iv_hi_q, iv_lo_q};
		end
		if (cnt == 0 && !padding_q && b.last_block) begin
			push_result('0, 5'd0, 1'b1, aes_cbc_pkg::ST_OK);
			return;
		end
		if (cnt > 16 || (cnt < 16 && (!b.last_block || !padding_q || !encrypt_q))) begin
			push_result('0, 5'd0, b.last_block, aes_cbc_pkg::ST_BAD_LEN);
			return;
		end
		x = {b.block_high, b.block_low};
		if (encrypt_q) begin
			extra = padding_q && b.last_block && cnt == 16;
			for (int i = 0; i < 16; i++) begin
				c[i] = chain_q[i] ^ ((i < cnt) ? x[i] : 8'(16 - cnt));
			end
			c = cipher_fwd(c);
			push_result(c, 5'd16, b.last_block && !extra, aes_cbc_pkg::ST_OK);
			if (extra) begin
				c = cipher_fwd(c ^ {16{8'h10}});
				push_result(c, 5'd16, 1'b1, aes_cbc_pkg::ST_OK);
			end
			chain_q = c;
		end else begin
			o = cipher_inv(x) ^ chain_q;
			chain_q = x;
			if (padding_q && b.last_block) begin
				p = o[15];
				if (p > 16) begin
					push_result('0, 5'd0, 1'b1, aes_cbc_pkg::ST_BAD_PAD);
				end else begin
					push_result(o, 5'(16 - p), 1'b1, aes_cbc_pkg::ST_OK);
				end
			end else begin
				push_result(o, 5'd16, b.last_block, aes_cbc_pkg::ST_OK);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one beat; valid stays high into the next call unless a gap is drawn.
	task automatic send_block(input aes_cbc_pkg::in_item_t b);
		int n;
		n = gaps_on ? pick_gap() : 0;
		if (n > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= b;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		predict_block(b);
	endtask

	function automatic aes_cbc_pkg::in_item_t make_block(input logic [127:0] d,
		input int cnt, input int first, input int last);
		aes_cbc_pkg::in_item_t b;
		b.block_high = d[127:64];
		b.block_low = d[63:0];
		b.byte_count = 5'(cnt);
		b.first_block = (first != 0);
		b.last_block = (last != 0);
		return b;
	endfunction

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Ciphertext that decrypts to pt under the chain the next beat will see.
	function automatic logic [127:0] seal_for(input blk_t pt, input int first);
		blk_t ch;
		ch = (first != 0) ? blk_t'({iv_hi_q, iv_lo_q}) : chain_q;
		return cipher_fwd(pt ^ ch);
	endfunction

	// Drain the engine, then write one register.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (expected_beats.size() == 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= val;
		@(negedge clk) write_en <= 1'b0;
		case (idx)
			aes_cbc_pkg::REG_KEY_HIGH: key_hi_q = val;
			aes_cbc_pkg::REG_KEY_LOW:  key_lo_q = val;
			aes_cbc_pkg::REG_IV_HIGH:  iv_hi_q = val;
			aes_cbc_pkg::REG_IV_LOW:   iv_lo_q = val;
			aes_cbc_pkg::REG_DIR:      encrypt_q = val[0];
			aes_cbc_pkg::REG_PAD:      padding_q = val[0];
			default: ;
		endcase
		if (idx == aes_cbc_pkg::REG_KEY_HIGH || idx == aes_cbc_pkg::REG_KEY_LOW) begin
			build_round_keys();
		end
		// round keys follow the key registers in the next cycle
		repeat (2) @(posedge clk);
	endtask

	task automatic set_mode(input bit enc, input bit pad);
		write_reg(aes_cbc_pkg::REG_DIR, {63'd0, enc});
		write_reg(aes_cbc_pkg::REG_PAD, {63'd0, pad});
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_encrypt_padded();
		write_reg(aes_cbc_pkg::REG_KEY_HIGH, 64'h0001020304050607);
		write_reg(aes_cbc_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		write_reg(aes_cbc_pkg::REG_IV_HIGH, 64'hffffffffffffffff);
		write_reg(aes_cbc_pkg::REG_IV_LOW, 64'h0);
		set_mode(1'b1, 1'b1);
		// full last block: data beat plus pad beat
		send_block(make_block(128'h00112233445566778899aabbccddeeff, 16, 1, 1));
		// empty last block, short one-byte and fifteen-byte ends
		send_block(make_block('1, 0, 1, 1));
		send_block(make_block('1, 1, 1, 1));
		send_block(make_block(rand128(), 15, 1, 1));
		// three-block message continuing the chain
		send_block(make_block('0, 16, 1, 0));
		send_block(make_block('1, 16, 0, 0));
		send_block(make_block(rand128(), 7, 0, 1));
		// short block that is not last, and counts beyond a block
		send_block(make_block(rand128(), 3, 1, 0));
		send_block(make_block(rand128(), 17, 0, 0));
		send_block(make_block(rand128(), 31, 0, 1));
	endtask

	task automatic test_decrypt_padded();
		blk_t pt;
		set_mode(1'b0, 1'b1);
		pt = rand128();
		send_block(make_block(rand128(), 16, 1, 0));
		pt[15] = 8'd0;
		send_block(make_block(seal_for(pt, 0), 16, 0, 1));
		pt[15] = 8'd16;
		send_block(make_block(seal_for(pt, 1), 16, 1, 1));
		pt[15] = 8'd17;
		send_block(make_block(seal_for(pt, 1), 16, 1, 1));
		pt[15] = 8'hff;
		send_block(make_block(seal_for(pt, 1), 16, 1, 1));
		// short block while decrypting
		send_block(make_block(rand128(), 12, 1, 1));
	endtask

	task automatic test_unpadded();
		set_mode(1'b1, 1'b0);
		send_block(make_block(rand128(), 16, 1, 1));
		send_block(make_block(rand128(), 0, 0, 1));
		send_block(make_block(rand128(), 9, 1, 1));
		set_mode(1'b0, 1'b0);
		send_block(make_block(rand128(), 16, 1, 0));
		send_block(make_block('1, 16, 0, 1));
		send_block(make_block(rand128(), 0, 1, 1));
	endtask

	task automatic run_message(input int nblk);
		blk_t pt;
		int cnt;
		bit last;
		for (int k = 0; k < nblk; k++) begin
			last = (k == nblk - 1);
			if ($urandom_range(0, 9) == 0) begin
				// noise: any count and any marks
				send_block(make_block(rand128(), $urandom_range(0, 31),
					$urandom_range(0, 1), $urandom_range(0, 1)));
			end else if (encrypt_q) begin
				cnt = (last && padding_q) ? $urandom_range(0, 16) : 16;
				if (last && !padding_q && $urandom_range(0, 7) == 0) cnt = 0;
				send_block(make_block(rand128(), cnt, k == 0, last));
			end else if (last && padding_q) begin
				pt = rand128();
				pt[15] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16));
				send_block(make_block(seal_for(pt, k == 0), 16, k == 0, last));
			end else begin
				send_block(make_block(rand128(), 16, k == 0, last));
			end
		end
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		for (int ph = 0; sent < 500; ph++) begin
			// extremes on the first phases, random keys and IVs after
			write_reg(aes_cbc_pkg::REG_KEY_HIGH,
				ph == 0 ? 64'h0 : ph == 1 ? '1 : {$urandom, $urandom});
			write_reg(aes_cbc_pkg::REG_KEY_LOW,
				ph == 0 ? 64'h0 : ph == 1 ? '1 : {$urandom, $urandom});
			write_reg(aes_cbc_pkg::REG_IV_HIGH,
				ph == 0 ? 64'h0 : ph == 1 ? '1 : {$urandom, $urandom});
			write_reg(aes_cbc_pkg::REG_IV_LOW,
				ph == 0 ? 64'h0 : ph == 1 ? '1 : {$urandom, $urandom});
			set_mode($urandom_range(0, 1) == 1, $urandom_range(0, 3) != 0);
			gaps_on = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			for (int m = 0; m < 8; m++) begin
				n = $urandom_range(1, 6);
				run_message(n);
				sent += n;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		aes_cbc_pkg::out_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat %h", out_data);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (out_data.result_high !== e.result_high) begin
					$error("result_high: expected %h, got %h", e.result_high, out_data.result_high);
					errors++;
				end
				if (out_data.result_low !== e.result_low) begin
					$error("result_low: expected %h, got %h", e.result_low, out_data.result_low);
					errors++;
				end
				if (out_data.result_bytes !== e.result_bytes) begin
					$error("result_bytes: expected %0d, got %0d", e.result_bytes,
						out_data.result_bytes);
					errors++;
				end
				if (out_data.result_last !== e.result_last) begin
					$error("result_last: expected %b, got %b", e.result_last, out_data.result_last);
					errors++;
				end
				if (out_data.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, out_data.status);
					errors++;
				end
			end
		end
	end

	// Random back-pressure on the result side.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = stalls_on ? pick_gap() : 0;
			if (n > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk) out_stall <= 1'b0;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || write_en) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= IDLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		write_en = 1'b0;
		write_index = '0;
		write_data = '0;
		errors = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		for (int i = 0; i < 256; i++) begin
			inv_box[aes_cbc_pkg::SBOX[i]] = 8'(i);
		end
		key_hi_q = '0;
		key_lo_q = '0;
		iv_hi_q = '0;
		iv_lo_q = '0;
		encrypt_q = 1'b1;
		padding_q = 1'b1;
		chain_q = '0;
		build_round_keys();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_encrypt_padded();
		test_decrypt_padded();
		test_unpadded();
		test_random();

		@(negedge clk) in_valid <= 1'b0;
		wait (expected_beats.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/aes_cbc_pkg.sv
hw/rtl/aes128_cbc_pkcs7_engine_core.sv
bench/tb_top.sv
